@@ sv/bba_pkg.sv @@
`timescale 1ns / 1ps
package bba_pkg;

   localparam int ADDR_W     = 64;
   localparam int SIZE_W     = 24;
   localparam int USED_W     = 11;
   localparam int WORD_BITS  = 64;
   localparam int WORD_IDX_W = 6;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic              command;
      logic [SIZE_W-1:0] size_bytes;
      logic [ADDR_W-1:0] free_address;
   } bba_req_type;

   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] block_address;
      logic [USED_W-1:0] used_count;
   } bba_rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_NEED,
      ST_FIRST,
      ST_DECIDE,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_MARK_INIT,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_FINISH
   } bba_state_type;

   typedef struct packed {
      logic cap;
      logic prep;
      logic mul_en;
      logic mul_dist;
      logic need_ld;
      logic first_ld;
      logic scan_rd;
      logic scan_ev;
      logic mark_init;
      logic mark_rd;
      logic mark_wr;
      logic clr_wr;
      logic finish;
   } bba_cmd_type;

   typedef struct packed {
      logic is_free;
      logic pre_ok;
      logic hit;
      logic scan_last;
      logic mark_last;
      logic clr_last;
   } bba_status_type;

endpackage

@@ sv/bba_ctrl.sv @@
`timescale 1ns / 1ps
module bba_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  bba_pkg::bba_status_type status,
   output bba_pkg::bba_cmd_type    cmd
);

   bba_pkg::bba_state_type state_ff;
   bba_pkg::bba_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bba_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         bba_pkg::ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_last) begin
               state_in = bba_pkg::ST_IDLE;
            end
         end
         bba_pkg::ST_IDLE: begin
            busy    = 1'b0;
            cmd.cap = start;
            if (start) begin
               state_in = bba_pkg::ST_PREP;
            end
         end
         bba_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = bba_pkg::ST_MUL;
         end
         bba_pkg::ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = bba_pkg::ST_NEED;
         end
         bba_pkg::ST_NEED: begin
            // size quotient lands, address offset goes through the multiplier
            cmd.need_ld  = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_dist = 1'b1;
            state_in     = bba_pkg::ST_FIRST;
         end
         bba_pkg::ST_FIRST: begin
            cmd.first_ld = 1'b1;
            state_in     = bba_pkg::ST_DECIDE;
         end
         bba_pkg::ST_DECIDE: begin
            if (!status.pre_ok) begin
               state_in = bba_pkg::ST_FINISH;
            end else if (status.is_free) begin
               state_in = bba_pkg::ST_MARK_INIT;
            end else begin
               state_in = bba_pkg::ST_SCAN_RD;
            end
         end
         bba_pkg::ST_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = bba_pkg::ST_SCAN_EV;
         end
         bba_pkg::ST_SCAN_EV: begin
            cmd.scan_ev = 1'b1;
            if (status.hit) begin
               state_in = bba_pkg::ST_MARK_INIT;
            end else if (status.scan_last) begin
               state_in = bba_pkg::ST_FINISH;
            end else begin
               state_in = bba_pkg::ST_SCAN_RD;
            end
         end
         bba_pkg::ST_MARK_INIT: begin
            cmd.mark_init = 1'b1;
            state_in      = bba_pkg::ST_MARK_RD;
         end
         bba_pkg::ST_MARK_RD: begin
            cmd.mark_rd = 1'b1;
            state_in    = bba_pkg::ST_MARK_WR;
         end
         bba_pkg::ST_MARK_WR: begin
            cmd.mark_wr = 1'b1;
            if (status.mark_last) begin
               state_in = bba_pkg::ST_FINISH;
            end else begin
               state_in = bba_pkg::ST_MARK_RD;
            end
         end
         bba_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = bba_pkg::ST_IDLE;
         end
         default: begin
            state_in = bba_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ sv/bba_datapath.sv @@
`timescale 1ns / 1ps
module bba_datapath #(
   parameter int NUM_BLOCKS  = 1024,
   parameter int BLOCK_BYTES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bba_pkg::bba_cmd_type              cmd,
   output bba_pkg::bba_status_type           status,
   input  bba_pkg::bba_req_type              req_data,
   input  logic                              csr_write,
   input  logic [bba_pkg::ADDR_W-1:0]        csr_data,
   output logic                              rsp_valid,
   output bba_pkg::bba_rsp_type              rsp_data
);

   localparam int AW         = bba_pkg::ADDR_W;
   localparam int SW         = bba_pkg::SIZE_W;
   localparam int UW         = bba_pkg::USED_W;
   localparam int WB         = bba_pkg::WORD_BITS;
   localparam int WIW        = bba_pkg::WORD_IDX_W;
   localparam int LW         = WIW + 1;
   localparam int ROWS       = (NUM_BLOCKS + WB - 1) / WB;
   localparam int RW         = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int GW         = RW + WIW;
   localparam int RUNW       = GW + 1;
   localparam int CW         = $clog2(NUM_BLOCKS + 1);
   localparam int POOL_BYTES = NUM_BLOCKS * BLOCK_BYTES;
   localparam int SIZE_RND_W = SW + 1;
   localparam int DIV_W      = ($clog2(POOL_BYTES) > SIZE_RND_W) ? $clog2(POOL_BYTES)
                                                                 : SIZE_RND_W;
   localparam int EW         = DIV_W + 1;
   localparam int SHIFT      = DIV_W + $clog2(BLOCK_BYTES);
   localparam int RECIP_W    = DIV_W + 2;
   localparam int PROD_W     = DIV_W + RECIP_W;
   localparam int OFFS_W     = GW + $clog2(BLOCK_BYTES + 1);
   // rounded-up reciprocal, exact quotient for every dividend below 2^DIV_W
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
   localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_FULL);
   localparam logic [RW-1:0]      LAST_ROW = RW'(ROWS - 1);

   // configuration and captured request
   logic [AW-1:0]     pool_base_ff;
   logic              cmd_free_ff;
   logic [SW-1:0]     size_ff;
   logic [AW-1:0]     addr_ff;

   // divide by block size
   logic [DIV_W-1:0]  n_size_ff;
   logic [DIV_W-1:0]  n_dist_ff;
   logic              alloc_pre_ff;
   logic              free_pre_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [DIV_W-1:0]  need_ff;
   logic [GW-1:0]     first_ff;
   logic [AW-1:0]     addr_gap;
   logic              free_pre_in;
   logic              alloc_pre_in;
   logic [DIV_W-1:0]  n_size_in;
   logic [DIV_W-1:0]  mul_a;
   logic [PROD_W-1:0] prod_in;
   logic [DIV_W-1:0]  quot;

   // scan
   logic [RW-1:0]     scan_row_ff;
   logic [RUNW-1:0]   run_ff;
   logic [GW-1:0]     start_ff;
   logic [LW-1:0]     len_a  [0:WIW][0:WB-1];
   logic              full_a [0:WIW][0:WB-1];
   logic [RUNW-1:0]   total  [0:WB-1];
   logic [WB-1:0]     hit_v;
   logic              hit_any;
   logic [WIW-1:0]    hit_idx;
   logic [RUNW-1:0]   start_in;

   // mark / clear
   logic [RW-1:0]     mark_row_ff;
   logic [RW-1:0]     mark_last_row_ff;
   logic [GW-1:0]     mark_lo_ff;
   logic [RUNW-1:0]   mark_hi_ff;
   logic [OFFS_W-1:0] offs_ff;
   logic              ok_ff;
   logic [RW-1:0]     clr_row_ff;
   logic [EW-1:0]     free_end;
   logic [GW-1:0]     lo_in;
   logic [RUNW-1:0]   hi_in;
   logic [RUNW-1:0]   hi_m1;
   logic [WB-1:0]     mark_mask;
   logic [WB-1:0]     wr_mark;

   // map memory
   logic [WB-1:0]     map_mem [0:ROWS-1];
   logic [WB-1:0]     rd_data_ff;
   logic              mem_we;
   logic [RW-1:0]     mem_waddr;
   logic [RW-1:0]     mem_raddr;
   logic [WB-1:0]     mem_wdata;

   // result
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic              rsp_valid_ff;
   bba_pkg::bba_rsp_type rsp_ff;
   bba_pkg::bba_rsp_type rsp_in;

   // request preparation
   always_comb begin
      addr_gap     = addr_ff - pool_base_ff;
      alloc_pre_in = (pool_base_ff != '0) && (size_ff != '0);
      free_pre_in  = alloc_pre_in && (addr_ff != '0) && (addr_ff >= pool_base_ff) &&
                     (addr_gap < AW'(POOL_BYTES));
      n_size_in    = DIV_W'(size_ff) + DIV_W'(BLOCK_BYTES - 1);
      mul_a        = cmd.mul_dist ? n_dist_ff : n_size_ff;
      prod_in      = PROD_W'(mul_a) * PROD_W'(RECIP);
      quot         = DIV_W'(prod_ff >> SHIFT);
   end

   // free-run lengths ending at each bit of the word, by doubling
   always_comb begin
      for (int j = 0; j < WB; j++) begin
         full_a[0][j] = !rd_data_ff[j] &&
                        (RUNW'({scan_row_ff, WIW'(j)}) < RUNW'(NUM_BLOCKS));
         len_a[0][j]  = LW'(full_a[0][j]);
      end
      for (int k = 0; k < WIW; k++) begin
         for (int j = 0; j < WB; j++) begin
            if (j >= (1 << k)) begin
               len_a[k+1][j]  = full_a[k][j] ? LW'(1 << k) + len_a[k][j - (1 << k)]
                                             : len_a[k][j];
               full_a[k+1][j] = full_a[k][j] && full_a[k][j - (1 << k)];
            end else begin
               len_a[k+1][j]  = full_a[k][j] ? LW'(1 << k) : len_a[k][j];
               full_a[k+1][j] = 1'b0;
            end
         end
      end
      for (int j = 0; j < WB; j++) begin
         // a run reaching bit zero continues the run from earlier words
         if (len_a[WIW][j] == LW'(j + 1)) begin
            total[j] = run_ff + RUNW'(j + 1);
         end else begin
            total[j] = RUNW'(len_a[WIW][j]);
         end
         hit_v[j] = total[j] >= RUNW'(need_ff);
      end
      hit_any = |hit_v;
      hit_idx = '0;
      for (int j = WB - 1; j >= 0; j--) begin
         if (hit_v[j]) begin
            hit_idx = WIW'(j);
         end
      end
      start_in = RUNW'({scan_row_ff, hit_idx}) + RUNW'(1) - RUNW'(need_ff);
   end

   // run bounds and row mask
   always_comb begin
      free_end = EW'(first_ff) + EW'(need_ff);
      if (cmd_free_ff) begin
         lo_in = first_ff;
         hi_in = (free_end < EW'(NUM_BLOCKS)) ? RUNW'(free_end) : RUNW'(NUM_BLOCKS);
      end else begin
         lo_in = start_ff;
         hi_in = RUNW'(start_ff) + RUNW'(need_ff);
      end
      hi_m1 = hi_in - RUNW'(1);
      for (int j = 0; j < WB; j++) begin
         mark_mask[j] = (RUNW'({mark_row_ff, WIW'(j)}) >= RUNW'(mark_lo_ff)) &&
                        (RUNW'({mark_row_ff, WIW'(j)}) < mark_hi_ff);
      end
      wr_mark = cmd_free_ff ? (rd_data_ff & ~mark_mask) : (rd_data_ff | mark_mask);
   end

   always_comb begin
      mem_we    = cmd.clr_wr || cmd.mark_wr;
      mem_waddr = cmd.clr_wr ? clr_row_ff : mark_row_ff;
      mem_wdata = cmd.clr_wr ? '0 : wr_mark;
      mem_raddr = cmd.mark_rd ? mark_row_ff : scan_row_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= map_mem[mem_raddr];
   end

   // count and result
   always_comb begin
      count_in = count_ff;
      if (ok_ff) begin
         if (cmd_free_ff) begin
            count_in = (DIV_W'(count_ff) >= need_ff) ? count_ff - CW'(need_ff) : '0;
         end else begin
            count_in = count_ff + CW'(need_ff);
         end
      end
      rsp_in.ok            = ok_ff;
      rsp_in.block_address = (ok_ff && !cmd_free_ff) ? pool_base_ff + AW'(offs_ff) : '0;
      rsp_in.used_count    = UW'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= '0;
         clr_row_ff   <= '0;
         count_ff     <= '0;
         ok_ff        <= 1'b0;
         scan_row_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
         if (csr_write) begin
            pool_base_ff <= csr_data;
         end
         if (cmd.clr_wr) begin
            clr_row_ff <= clr_row_ff + RW'(1);
         end
         if (cmd.cap) begin
            ok_ff       <= 1'b0;
            scan_row_ff <= '0;
         end else if (cmd.mark_init) begin
            ok_ff <= 1'b1;
         end else if (cmd.scan_ev && !hit_any && !status.scan_last) begin
            scan_row_ff <= scan_row_ff + RW'(1);
         end
         if (cmd.finish) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         cmd_free_ff <= (req_data.command == bba_pkg::CMD_FREE);
         size_ff     <= req_data.size_bytes;
         addr_ff     <= req_data.free_address;
         run_ff      <= '0;
      end
      if (cmd.prep) begin
         n_size_ff    <= n_size_in;
         n_dist_ff    <= DIV_W'(addr_gap);
         alloc_pre_ff <= alloc_pre_in;
         free_pre_ff  <= free_pre_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.need_ld) begin
         need_ff <= quot;
      end
      if (cmd.first_ld) begin
         first_ff <= GW'(quot);
      end
      if (cmd.scan_ev) begin
         if (hit_any) begin
            start_ff <= GW'(start_in);
         end else begin
            run_ff <= total[WB-1];
         end
      end
      if (cmd.mark_init) begin
         mark_lo_ff       <= lo_in;
         mark_hi_ff       <= hi_in;
         mark_row_ff      <= RW'(lo_in >> WIW);
         mark_last_row_ff <= RW'(hi_m1 >> WIW);
         offs_ff          <= OFFS_W'(start_ff) * OFFS_W'(BLOCK_BYTES);
      end else if (cmd.mark_wr) begin
         mark_row_ff <= mark_row_ff + RW'(1);
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      status.is_free   = cmd_free_ff;
      status.pre_ok    = cmd_free_ff ? free_pre_ff
                                     : (alloc_pre_ff && (need_ff <= DIV_W'(NUM_BLOCKS)));
      status.hit       = hit_any;
      status.scan_last = (scan_row_ff == LAST_ROW);
      status.mark_last = (mark_row_ff == mark_last_row_ff);
      status.clr_last  = (clr_row_ff == LAST_ROW);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ sv/bitmap_block_allocator_top.sv @@
`timescale 1ns / 1ps
// First-fit block allocator over a pool of NUM_BLOCKS blocks of BLOCK_BYTES bytes,
// one used bit per block, held as 64-bit words in a single memory.
// csr_*: write channel for the pool base address; always ready, write only while idle.
// request: start with req_data is taken when busy is low. command 0 allocates
//   size_bytes rounded up to whole blocks, command 1 frees from free_address.
// response: rsp_valid strobes for one cycle with rsp_data (ok, address, used count);
//   the receiver cannot hold it off, and busy drops in that same cycle.
// after a request is accepted, a rejected one goes straight to the response;
// a free marks the words it touches, with one read and one write per word;
// an allocation scans the map a word at a time, reading and evaluating each,
// and on a fit marks the run with one read and one write per word;
// an allocation with no fit responds after the last word has been scanned.
// requests are handled one at a time; the next can start in the strobe cycle.
// reset clears the base and used count, then sweeps the map to all free:
//   busy stays high after reset until every map word has been cleared.
module bitmap_block_allocator_top #(
   parameter int NUM_BLOCKS  = 1024,
   parameter int BLOCK_BYTES = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  bba_pkg::bba_req_type       req_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [bba_pkg::ADDR_W-1:0] csr_data,
   output logic                       rsp_valid,
   output bba_pkg::bba_rsp_type       rsp_data
);

   bba_pkg::bba_cmd_type    cmd;
   bba_pkg::bba_status_type status;
   logic                    csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   bba_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   bba_datapath #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ sv/bba_checker.sv @@
`timescale 1ns / 1ps
module bba_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input bba_pkg::bba_rsp_type rsp_data
);

   // an accepted request keeps the block busy until its response
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after request accepted");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("response in the cycle after acceptance");

   // one response per request
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while still busy");

   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ok) |-> (rsp_data.block_address == '0))
      else $error("failed request returned a nonzero address");

endmodule

bind bitmap_block_allocator_top bba_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
